// ----- hw/rtl/zzidct_pkg.sv -----
// package for the zigzag 8x8 inverse dct
// holds widths, the zigzag map, the basis table and the state types; no dependencies
package zzidct_pkg;

    localparam int FRAC_BITS  = 13;
    localparam int COEF_W     = 16;
    localparam int BASIS_W    = FRAC_BITS + 2;
    localparam int PART_W     = 34;
    localparam int ACC_W      = 52;
    localparam int SHIFT      = 2 * FRAC_BITS + 2;

    typedef enum logic [1:0] {
        t_ST_LOAD,
        t_ST_ROW,
        t_ST_COL
    } t_state;

    typedef struct packed {
        logic       start;
        logic [0:0] bank;
    } t_blk_req;

    function automatic logic [5:0] zz_to_nat(input logic [5:0] z);
        logic [5:0] r;
        case (z)
            6'd0: r = 6'd0;    6'd1: r = 6'd1;    6'd2: r = 6'd8;    6'd3: r = 6'd16;
            6'd4: r = 6'd9;    6'd5: r = 6'd2;    6'd6: r = 6'd3;    6'd7: r = 6'd10;
            6'd8: r = 6'd17;   6'd9: r = 6'd24;   6'd10: r = 6'd32;  6'd11: r = 6'd25;
            6'd12: r = 6'd18;  6'd13: r = 6'd11;  6'd14: r = 6'd4;   6'd15: r = 6'd5;
            6'd16: r = 6'd12;  6'd17: r = 6'd19;  6'd18: r = 6'd26;  6'd19: r = 6'd33;
            6'd20: r = 6'd40;  6'd21: r = 6'd48;  6'd22: r = 6'd41;  6'd23: r = 6'd34;
            6'd24: r = 6'd27;  6'd25: r = 6'd20;  6'd26: r = 6'd13;  6'd27: r = 6'd6;
            6'd28: r = 6'd7;   6'd29: r = 6'd14;  6'd30: r = 6'd21;  6'd31: r = 6'd28;
            6'd32: r = 6'd35;  6'd33: r = 6'd42;  6'd34: r = 6'd49;  6'd35: r = 6'd56;
            6'd36: r = 6'd57;  6'd37: r = 6'd50;  6'd38: r = 6'd43;  6'd39: r = 6'd36;
            6'd40: r = 6'd29;  6'd41: r = 6'd22;  6'd42: r = 6'd15;  6'd43: r = 6'd23;
            6'd44: r = 6'd30;  6'd45: r = 6'd37;  6'd46: r = 6'd44;  6'd47: r = 6'd51;
            6'd48: r = 6'd58;  6'd49: r = 6'd59;  6'd50: r = 6'd52;  6'd51: r = 6'd45;
            6'd52: r = 6'd38;  6'd53: r = 6'd31;  6'd54: r = 6'd39;  6'd55: r = 6'd46;
            6'd56: r = 6'd53;  6'd57: r = 6'd60;  6'd58: r = 6'd61;  6'd59: r = 6'd54;
            6'd60: r = 6'd47;  6'd61: r = 6'd55;  6'd62: r = 6'd62;  default: r = 6'd63;
        endcase
        return r;
    endfunction

    // cos(m*pi/16) in q32
    function automatic logic [32:0] cos_q32(input logic [3:0] m);
        logic [32:0] r;
        case (m)
            4'd0: r = 33'd4294967296;
            4'd1: r = 33'd4212440704;
            4'd2: r = 33'd3968032378;
            4'd3: r = 33'd3571134792;
            4'd4: r = 33'd3037000500;
            4'd5: r = 33'd2386155981;
            4'd6: r = 33'd1643612827;
            4'd7: r = 33'd837906553;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

    // basis T[x][u] at FRAC_BITS fraction bits
    function automatic logic signed [BASIS_W-1:0] basis(input logic [2:0] x, input logic [2:0] u);
        logic [32:0] mag;
        logic [33:0] rnd;
        logic [4:0]  m;
        logic        neg;
        neg = 1'b0;
        m   = 5'(({2'b0, x, 1'b1} * {2'b0, u}));
        if (u == 3'd0) begin
            mag = cos_q32(4'd4);
        end else begin
            if (m > 5'd16) m = 5'(6'd32 - {1'b0, m});
            if (m > 5'd8) begin
                m   = 5'd16 - m;
                neg = 1'b1;
            end
            mag = cos_q32(m[3:0]);
        end
        rnd = ({1'b0, mag} + (34'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        return neg ? -$signed(BASIS_W'(rnd)) : $signed(BASIS_W'(rnd));
    endfunction

endpackage

// ----- hw/rtl/zzidct_ram.sv -----
// generic single-port-write, registered-read ram
// no dependencies
module zzidct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/zzidct_front.sv -----
// front: accepts zigzag coefficients and files them in natural order into a two-bank store
// depends on zzidct_pkg, zzidct_ram
module zzidct_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [15:0]    i_coefficient,
    output zzidct_pkg::t_blk_req  o_req,
    input  logic                  i_done,
    input  logic [6:0]            i_raddr,
    output logic signed [15:0]    o_rdata
);
    logic [5:0] r_count;
    logic [0:0] r_bank;
    logic [0:0] r_free;
    logic [1:0] r_full;
    logic       acc;
    logic [6:0] waddr;
    logic [1:0] n_full;

    // bank ahead free only if full flag clear
    assign o_stall = r_full[r_bank];
    assign acc     = i_valid && !o_stall;
    assign waddr   = {r_bank, zzidct_pkg::zz_to_nat(r_count)};
    assign o_req.start = acc && (r_count == 6'd63);
    assign o_req.bank  = r_bank;

    // back starting a block releases the bank of the block before it
    always_comb begin
        n_full = r_full;
        if (i_done) n_full[r_free] = 1'b0;
        if (o_req.start) n_full[r_bank] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= '0;
            r_free  <= 1'b1;
            r_full  <= '0;
        end else begin
            r_full <= n_full;
            if (i_done) r_free <= ~r_free;
            if (acc) begin
                r_count <= r_count + 6'd1;
                if (r_count == 6'd63) r_bank <= ~r_bank;
            end
        end
    end

    zzidct_ram #(.WIDTH(zzidct_pkg::COEF_W), .DEPTH(128)) u_coef (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (waddr),
        .i_wdata (i_coefficient),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );

`ifndef SYNTH
    a_start_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |=> r_full[$past(r_bank)]) else $error("bank not marked full");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> !r_full[r_bank]) else $error("write into full bank");
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |=> r_bank != $past(r_bank)) else $error("bank did not flip");
`endif
endmodule

// ----- hw/rtl/zzidct_back.sv -----
// back: a shared accumulator runs the row pass then the column pass and streams samples
// depends on zzidct_pkg, zzidct_ram
module zzidct_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [0:0]            i_bank,
    output logic                  o_done,
    output logic [6:0]            o_raddr,
    input  logic signed [15:0]    i_rdata,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_sample,
    output logic [2:0]            o_row,
    output logic [2:0]            o_col,
    output logic                  o_last_of_block
);
    localparam int PW = zzidct_pkg::PART_W;
    localparam int AW = zzidct_pkg::ACC_W;

    zzidct_pkg::t_state r_state, n_state;
    logic [0:0] r_bank;
    logic       r_pend;
    logic [0:0] r_pbank;
    // index: {outer(6), k(3)} where outer = {a,b}
    logic [8:0] r_idx, n_idx;
    logic [8:0] r_idx_d;
    logic       r_vld_d;
    logic       r_vld_m;
    logic [8:0] r_idx_m;
    logic signed [PW-1:0] r_prod_r;
    logic signed [AW-1:0] r_prod_c;
    logic signed [AW-1:0] r_acc;
    logic signed [PW-1:0] part_rd;
    logic signed [zzidct_pkg::BASIS_W-1:0] w_row, w_col;
    logic signed [PW-1:0] prod_r;
    logic signed [AW-1:0] prod_c;
    logic [5:0] p_raddr;
    logic       p_we;
    logic [5:0] p_waddr;
    logic       issue;
    logic       r_ov;
    logic signed [15:0] r_os;
    logic [2:0] r_orow, r_ocol;
    logic       r_olast;
    logic       fin;
    logic signed [AW-1:0] s_total, mag, q;
    logic signed [15:0] sat;
    logic       r_colmode_d, r_colmode_m;
    logic       fin_o;

    // row pass: idx={u,j,v}; coef at {u,v}; partial addr {u,j}
    // col pass: idx={i,j,u}; partial at {u,j}
    assign o_raddr = {r_bank, r_idx[8:6], r_idx[2:0]};
    assign p_raddr = {r_idx[2:0], r_idx[5:3]};

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        issue   = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            zzidct_pkg::t_ST_LOAD: begin
                if (r_pend || i_start) begin
                    n_state = zzidct_pkg::t_ST_ROW;
                    n_idx   = '0;
                    o_done  = 1'b1;
                end
            end
            zzidct_pkg::t_ST_ROW: begin
                issue = 1'b1;
                n_idx = r_idx + 9'd1;
                if (r_idx == 9'd511) begin
                    n_state = zzidct_pkg::t_ST_COL;
                end
            end
            zzidct_pkg::t_ST_COL: begin
                // one column sum per group of eight products, then a drain; stall holds issue at group start
                if (!(r_idx[2:0] == 3'd0 && (r_ov && i_stall || r_vld_d || r_vld_m))
                    || r_idx == 9'd0 && !r_vld_d && !r_vld_m && !(r_ov && i_stall)) begin
                    issue = !(r_idx == 9'd0 && fin);
                end
                if (r_idx == 9'd0 && fin) begin
                    issue = 1'b0;
                end
                if (issue) n_idx = r_idx + 9'd1;
                if (issue && r_idx == 9'd511) n_state = zzidct_pkg::t_ST_LOAD;
            end
            default: n_state = zzidct_pkg::t_ST_LOAD;
        endcase
    end

    assign fin = 1'b0;

    // stage d: ram data valid; stage m: product valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zzidct_pkg::t_ST_LOAD;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_m <= 1'b0;
            r_ov    <= 1'b0;
            r_bank  <= '0;
            r_pbank <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_vld_d <= issue;
            r_vld_m <= r_vld_d;
            if (i_start && r_state != zzidct_pkg::t_ST_LOAD) begin
                r_pend  <= 1'b1;
                r_pbank <= i_bank;
            end else if (r_state == zzidct_pkg::t_ST_LOAD && (r_pend || i_start)) begin
                r_pend <= 1'b0;
            end
            if (r_state == zzidct_pkg::t_ST_LOAD) begin
                if (r_pend) r_bank <= r_pbank;
                else if (i_start) r_bank <= i_bank;
            end
            if (fin_o) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    assign w_row  = zzidct_pkg::basis(r_idx_d[5:3], r_idx_d[2:0]);
    assign w_col  = zzidct_pkg::basis(r_idx_d[8:6], r_idx_d[2:0]);
    assign prod_r = i_rdata * w_row;
    assign prod_c = part_rd * w_col;

    always_ff @(posedge i_clk) begin
        r_idx_d     <= r_idx;
        r_colmode_d <= (r_state == zzidct_pkg::t_ST_COL);
        r_idx_m     <= r_idx_d;
        r_colmode_m <= r_colmode_d;
        r_prod_r    <= prod_r;
        r_prod_c    <= prod_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_vld_m) begin
            if (r_idx_m[2:0] == 3'd0)
                r_acc <= r_colmode_m ? r_prod_c : AW'(r_prod_r);
            else
                r_acc <= r_acc + (r_colmode_m ? r_prod_c : AW'(r_prod_r));
        end
    end

    // final term folded into total combinationally, without going through the accumulator
    assign s_total = (r_idx_m[2:0] == 3'd0) ? (r_colmode_m ? r_prod_c : AW'(r_prod_r))
                   : r_acc + (r_colmode_m ? r_prod_c : AW'(r_prod_r));
    assign p_we    = r_vld_m && !r_colmode_m && r_idx_m[2:0] == 3'd7;
    assign p_waddr = {r_idx_m[8:6], r_idx_m[5:3]};
    assign fin_o   = r_vld_m && r_colmode_m && r_idx_m[2:0] == 3'd7;

    assign mag = s_total[AW-1] ? -s_total : s_total;
    always_comb begin
        q = mag >>> zzidct_pkg::SHIFT;
        if (s_total[AW-1]) q = -q;
        if (q > 52'sd32767) sat = 16'sd32767;
        else if (q < -52'sd32768) sat = -16'sd32768;
        else sat = q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (fin_o) begin
            r_os    <= sat;
            r_orow  <= r_idx_m[8:6];
            r_ocol  <= r_idx_m[5:3];
            r_olast <= r_idx_m[8:3] == 6'd63;
        end
    end

    zzidct_ram #(.WIDTH(PW), .DEPTH(64)) u_part (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (PW'(s_total)),
        .i_raddr (p_raddr),
        .o_rdata (part_rd)
    );

    assign o_valid         = r_ov;
    assign o_sample        = r_os;
    assign o_row           = r_orow;
    assign o_col           = r_ocol;
    assign o_last_of_block = r_olast;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_o |-> !(r_ov && i_stall)) else $error("output overwritten while stalled");
    a_start_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == zzidct_pkg::t_ST_ROW) else $error("block start lost");
    a_pend_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !(i_start && r_state != zzidct_pkg::t_ST_LOAD))
        else $error("second pending block");
`endif
endmodule

// ----- hw/rtl/zigzag_idct_8x8.sv -----
// top level of the zigzag 8x8 inverse dct
// depends on zzidct_pkg, zzidct_front, zzidct_back
//
// input channel: one coefficient per request in zigzag order, i_valid/o_stall.
// output channel: 64 samples per block in row-major order, o_valid/i_stall,
// row and col tag each sample, last_of_block flags the 64th.
// the front files coefficients into a two-bank store at one per cycle while not
// stalled; after the 64th the back runs a row pass and a column pass (with a
// pipeline drain per sample) through one shared accumulator and a multiplier per
// pass. the back, not the front, sets the sustained block rate.
// the front fills the other bank while the back works, and stalls once a full
// block waits behind the one in the back.
// a stalled receiver freezes the column pass at the next sample boundary; the
// output register holds its sample.
// reset clears counters, bank flags and output valid; stores need no clearing.
module zigzag_idct_8x8 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_coefficient,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample,
    output logic [2:0]         o_row,
    output logic [2:0]         o_col,
    output logic               o_last_of_block
);
    zzidct_pkg::t_blk_req req;
    logic               done;
    logic [6:0]         raddr;
    logic signed [15:0] rdata;

    zzidct_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_coefficient (i_coefficient),
        .o_req         (req),
        .i_done        (done),
        .i_raddr       (raddr),
        .o_rdata       (rdata)
    );

    zzidct_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (req.start),
        .i_bank          (req.bank),
        .o_done          (done),
        .o_raddr         (raddr),
        .i_rdata         (rdata),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sample        (o_sample),
        .o_row           (o_row),
        .o_col           (o_col),
        .o_last_of_block (o_last_of_block)
    );
endmodule

// ----- tb/tb_top.sv -----
// testbench for zigzag_idct_8x8: drives zigzag coefficient blocks with random idling
// and checks every sample against an integer idct predictor; depends on zzidct_pkg
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic signed [15:0] sample;
        logic [2:0]         row;
        logic [2:0]         col;
        logic               last;
    } t_sample;

    typedef struct {
        logic signed [15:0] coef;
        logic               has_exp;
        logic signed [15:0] exp_first;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_coefficient;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_sample;
    logic [2:0]         o_row;
    logic [2:0]         o_col;
    logic               o_last_of_block;

    zigzag_idct_8x8 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_coefficient(i_coefficient), .o_valid(o_valid), .i_stall(i_stall),
        .o_sample(o_sample), .o_row(o_row), .o_col(o_col),
        .o_last_of_block(o_last_of_block)
    );

    t_sample            expected_samples[$];
    logic signed [15:0] block_coefs[64];
    logic [5:0]         zz_pos;
    int                 fail_count;
    int                 mismatch_count;
    int                 sample_count;
    int                 block_count;
    int                 cycle_count;
    logic               rx_holdoff;
    logic               rx_busy_free;
    logic               tx_busy_free;

    // cosine magnitudes in q32 for m = 0..8
    function automatic longint cos_mag(int m);
        case (m)
            0: return 64'd4294967296;
            1: return 64'd4212440704;
            2: return 64'd3968032378;
            3: return 64'd3571134792;
            4: return 64'd3037000500;
            5: return 64'd2386155981;
            6: return 64'd1643612827;
            7: return 64'd837906553;
            default: return 64'd0;
        endcase
    endfunction

    function automatic longint idct_weight(int x, int u);
        longint mag;
        int     m;
        bit     neg;
        neg = 0;
        if (u == 0) begin
            mag = 64'd3037000500;
        end else begin
            m = ((2 * x + 1) * u) % 32;
            if (m > 16) m = 32 - m;
            if (m > 8) begin
                m = 16 - m;
                neg = 1;
            end
            mag = cos_mag(m);
        end
        mag = (mag + (64'sd1 << (31 - zzidct_pkg::FRAC_BITS))) >>> (32 - zzidct_pkg::FRAC_BITS);
        return neg ? -mag : mag;
    endfunction

    // natural-order position of zigzag index, built by walking diagonals
    int zz_map[64];

    task automatic build_zz_map();
        int r;
        int c;
        int k;
        r = 0;
        c = 0;
        for (k = 0; k < 64; k++) begin
            zz_map[k] = r * 8 + c;
            if (((r + c) % 2) == 0) begin
                if (c == 7) r++;
                else if (r == 0) c++;
                else begin
                    r--;
                    c++;
                end
            end else begin
                if (r == 7) c++;
                else if (c == 0) r++;
                else begin
                    r++;
                    c--;
                end
            end
        end
    endtask

    task automatic predict_block();
        longint  row_sum[64];
        longint  acc;
        longint  q;
        t_sample s;
        int      i, j, u, v;
        for (u = 0; u < 8; u++)
            for (j = 0; j < 8; j++) begin
                acc = 0;
                for (v = 0; v < 8; v++)
                    acc += longint'(block_coefs[u * 8 + v]) * idct_weight(j, v);
                row_sum[u * 8 + j] = acc;
            end
        for (i = 0; i < 8; i++)
            for (j = 0; j < 8; j++) begin
                acc = 0;
                for (u = 0; u < 8; u++)
                    acc += idct_weight(i, u) * row_sum[u * 8 + j];
                q = acc / (64'sd1 <<< zzidct_pkg::SHIFT);
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                s.sample = 16'(q);
                s.row    = 3'(i);
                s.col    = 3'(j);
                s.last   = (i == 7 && j == 7);
                expected_samples.insert(expected_samples.size(), s);
            end
    endtask

    task automatic file_coef(logic signed [15:0] c);
        block_coefs[zz_map[zz_pos]] = c;
        zz_pos = zz_pos + 6'd1;
        if (zz_pos == 6'd0) begin
            predict_block();
            block_count++;
        end
    endtask

    task automatic send_coef(logic signed [15:0] c, bit allow_idle);
        if (allow_idle && !tx_busy_free)
            while ($urandom_range(99) < 23) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_valid       <= 1'b1;
        i_coefficient <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        file_coef(c);
    endtask

    function automatic logic signed [15:0] rand_coef(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 200)) - 100);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'sd0;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL zigzag_idct_8x8");
                $finish;
            end
        end
    end

    // receiver: random stall, one long hold-off, a calm stretch
    initial begin
        i_stall <= 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_holdoff) begin
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                rx_holdoff = 1'b0;
            end else begin
                i_stall <= (!rx_busy_free && $urandom_range(99) < 23);
                @(posedge i_clk);
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n && o_valid && !i_stall) begin
            sample_count++;
            if (expected_samples.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected sample %0d at row %0d col %0d",
                             o_sample, o_row, o_col);
            end else begin
                e = expected_samples.pop_front();
                if (o_sample !== e.sample || o_row !== e.row || o_col !== e.col
                        || o_last_of_block !== e.last) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d r%0d c%0d l%0b got %0d r%0d c%0d l%0b",
                                 e.sample, e.row, e.col, e.last,
                                 o_sample, o_row, o_col, o_last_of_block);
                end
            end
        end
    end

    t_stim_row directed[$];

    task automatic add_block(int kind);
        t_stim_row r;
        int        k;
        for (k = 0; k < 64; k++) begin
            r.has_exp = 0;
            r.exp_first = 0;
            case (kind)
                0: r.coef = 16'sd0;
                1: r.coef = (k == 0) ? 16'sh7fff : 16'sd0;
                2: r.coef = (k == 0) ? 16'sh8000 : 16'sd0;
                3: r.coef = (k[0]) ? 16'sh8000 : 16'sh7fff;
                default: r.coef = 16'sh7fff;
            endcase
            // all-zero block gives zero; dc-only blocks stay flat
            if (k == 63 && kind == 0) begin
                r.has_exp = 1;
                r.exp_first = 16'sd0;
            end
            directed.insert(directed.size(), r);
        end
    endtask

    initial begin
        t_stim_row r;
        int        k;
        int        exp_at;
        build_zz_map();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_coefficient <= '0;
        zz_pos        = 6'd0;
        fail_count    = 0;
        mismatch_count = 0;
        sample_count  = 0;
        block_count   = 0;
        rx_holdoff    = 1'b0;
        rx_busy_free  = 1'b0;
        tx_busy_free  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed block right after reset: all zero
        add_block(0);
        for (k = 0; k < directed.size(); k++) begin
            r = directed[k];
            exp_at = expected_samples.size();
            send_coef(r.coef, 1'b1);
            if (r.has_exp && expected_samples[exp_at].sample !== r.exp_first) begin
                fail_count++;
                $display("predictor disagrees with typed-in value at row %0d", k);
            end
        end

        // sender pause until every sample has come
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);

        // receiver holds off while the sender keeps offering full-scale and random blocks
        rx_holdoff = 1'b1;
        for (k = 0; k < 64; k++) send_coef(rand_coef(2), 1'b1);
        for (k = 0; k < 64; k++) send_coef(rand_coef(0), 1'b1);

        // sparse block sent with no idling and no receiver stall while it is sent, queued behind the hold-off
        rx_busy_free = 1'b1;
        tx_busy_free = 1'b1;
        for (k = 0; k < 64; k++) send_coef((k < 10) ? rand_coef(1) : 16'sd0, 1'b1);
        rx_busy_free = 1'b0;
        tx_busy_free = 1'b0;
        i_valid <= 1'b0;

        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("%0d blocks, %0d samples checked; zero block after reset, full-scale,",
                 block_count, sample_count);
        $display("random and sparse blocks under stalls and a long output hold-off");
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("PASS zigzag_idct_8x8");
        end else begin
            $display("FAIL zigzag_idct_8x8");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/zzidct_pkg.sv
hw/rtl/zzidct_ram.sv
hw/rtl/zzidct_front.sv
hw/rtl/zzidct_back.sv
hw/rtl/zigzag_idct_8x8.sv
tb/tb_top.sv
